>>> src/irq_timing_jitter_monitor_unit_defines.svh
// Assertion macros shared by the interrupt timing jitter monitor RTL.
`ifndef IRQ_TIMING_JITTER_MONITOR_UNIT_DEFINES_SVH
`define IRQ_TIMING_JITTER_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ITJM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ITJM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/itjm_pkg.sv
// Types and constants shared by the interrupt timing jitter monitor modules.
`timescale 1ns / 1ps
`default_nettype none

package itjm_pkg;

  localparam int TS_W   = 32;   // timestamp and statistics width
  localparam int CPU_W  = 10;   // cycles per microsecond width
  localparam int MAG_W  = 42;   // magnitude of interval minus ideal cycles
  localparam int DIFF_W = 43;   // signed interval minus ideal cycles
  localparam int CFG_IDX_W = 2;

  // Input item modes
  localparam logic [1:0] MODE_ENTRY = 2'd0;
  localparam logic [1:0] MODE_EXIT  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Commands from front to back
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_JITTER = 2'd2;
  localparam logic [1:0] OP_EXEC   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_US = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDEAL_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd2;

  typedef struct packed {
    logic [1:0]      mode;
    logic [TS_W-1:0] timestamp;
  } itjm_in_t;

  typedef struct packed {
    logic [TS_W-1:0]        samples_total;
    logic [TS_W-1:0]        violations_total;
    logic signed [TS_W-1:0] jitter_last;
    logic signed [TS_W-1:0] jitter_min;
    logic signed [TS_W-1:0] jitter_max;
    logic [TS_W-1:0]        exec_last;
    logic [TS_W-1:0]        exec_min;
    logic [TS_W-1:0]        exec_max;
  } itjm_out_t;

  // Classified work: neg/mag is the signed dividend for the back end
  typedef struct packed {
    logic [1:0]       op;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } itjm_cmd_t;

endpackage

`default_nettype wire

>>> src/itjm_queue.sv
// Small command queue between the classifying front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "irq_timing_jitter_monitor_unit_defines.svh"

module itjm_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire itjm_pkg::itjm_cmd_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output itjm_pkg::itjm_cmd_t    pop_data,
  output logic                   empty
);
  import itjm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  itjm_cmd_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  `ITJM_ASSERT_IMPL(a_no_push_full, push, !full, "queue pushed while full")
  `ITJM_ASSERT_IMPL(a_no_pop_empty, pop, !empty, "queue popped while empty")

endmodule

`default_nettype wire

>>> src/itjm_front.sv
// Front end: accepts items, tracks entry times and classifies the work.
`timescale 1ns / 1ps
`default_nettype none

module itjm_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire itjm_pkg::itjm_in_t         in_data,
  input  wire logic [itjm_pkg::CPU_W-1:0] us_ticks,
  input  wire logic [itjm_pkg::TS_W-1:0]  period_goal_us,
  output logic                            q_push,
  output itjm_pkg::itjm_cmd_t             q_data,
  input  wire logic                       q_full
);
  import itjm_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]        fstate_r, fstate_nxt;
  itjm_in_t          item_r;
  logic [MAG_W-1:0]  prod_r, prod_full;
  logic              primed_r;
  logic [TS_W-1:0]   ref_r, last_r;

  logic [TS_W-1:0]   interval, exec_cyc;
  logic [DIFF_W-1:0] diff, diff_neg;
  logic              tb_ok, upd_entry, set_ref;

  assign in_ready = (fstate_r == F_IDLE);

  // Ideal period in cycles, at most 1023 * (2^32 - 1)
  assign prod_full = {{(MAG_W - TS_W){1'b0}}, period_goal_us}
                   * {{(MAG_W - CPU_W){1'b0}}, us_ticks};

  assign interval = item_r.timestamp - ref_r;
  assign exec_cyc = item_r.timestamp - last_r;
  assign diff     = {{(DIFF_W - TS_W){1'b0}}, interval} - {1'b0, prod_r};
  assign diff_neg = '0 - diff;
  assign tb_ok    = (us_ticks != '0);

  // Classify the held item
  always_comb begin
    q_data.op  = OP_READ;
    q_data.neg = 1'b0;
    q_data.mag = '0;
    upd_entry  = 1'b0;
    set_ref    = 1'b0;
    case (item_r.mode)
      MODE_ENTRY: begin
        if (tb_ok) begin
          upd_entry = 1'b1;
          set_ref   = 1'b1;
          if (primed_r) begin
            q_data.op  = OP_JITTER;
            q_data.neg = diff[DIFF_W-1];
            q_data.mag = diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
          end
        end
      end
      MODE_EXIT: begin
        if (tb_ok && primed_r) begin
          q_data.op  = OP_EXEC;
          q_data.mag = {{(MAG_W - TS_W){1'b0}}, exec_cyc};
        end
      end
      MODE_CLEAR: q_data.op = OP_CLEAR;
      MODE_READ:  q_data.op = OP_READ;
      default:    q_data.op = OP_READ;
    endcase
  end

  assign q_push = (fstate_r == F_PUSH) && !q_full;

  always_comb begin
    fstate_nxt = fstate_r;
    case (fstate_r)
      F_IDLE:  if (in_valid) fstate_nxt = F_MUL;
      F_MUL:   fstate_nxt = F_PUSH;
      F_PUSH:  if (!q_full) fstate_nxt = F_IDLE;
      default: fstate_nxt = F_IDLE;
    endcase
  end

  // Item and product registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (fstate_r == F_MUL) begin
      prod_r <= prod_full;
    end
  end

  // Control and entry reference state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r <= F_IDLE;
      primed_r <= 1'b0;
      ref_r    <= '0;
      last_r   <= '0;
    end else begin
      fstate_r <= fstate_nxt;
      if (q_push && upd_entry) begin
        last_r   <= item_r.timestamp;
        primed_r <= 1'b1;
      end
      if (q_push && set_ref) begin
        ref_r <= item_r.timestamp;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/itjm_div.sv
// Restoring divider: one quotient bit per cycle by cycles per microsecond.
`timescale 1ns / 1ps
`default_nettype none

module itjm_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [itjm_pkg::MAG_W-1:0] dividend,
  input  wire logic [itjm_pkg::CPU_W-1:0] divisor,
  output logic                            done,
  output logic [itjm_pkg::MAG_W-1:0]      quotient
);
  import itjm_pkg::*;

  localparam int STEP_W = $clog2(MAG_W);

  logic              busy_r, done_r;
  logic [STEP_W-1:0] step_r;
  logic [CPU_W-1:0]  rem_r, rem_nxt;
  logic [MAG_W-1:0]  quo_r;
  logic [CPU_W:0]    shifted, trial;
  logic              fits;

  assign shifted = {rem_r, quo_r[MAG_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = (shifted >= {1'b0, divisor});
  assign rem_nxt = fits ? trial[CPU_W-1:0] : shifted[CPU_W-1:0];

  assign done     = done_r;
  assign quotient = quo_r;

  // Dividend shifts out of the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[MAG_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(MAG_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> src/itjm_back.sv
// Back end: divides, saturates, updates statistics and holds the result.
`timescale 1ns / 1ps
`default_nettype none
`include "irq_timing_jitter_monitor_unit_defines.svh"

module itjm_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [itjm_pkg::CPU_W-1:0] us_ticks,
  input  wire logic [itjm_pkg::TS_W-1:0]  jit_limit_us,
  output logic                            q_pop,
  input  wire itjm_pkg::itjm_cmd_t        q_data,
  input  wire logic                       q_empty,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output itjm_pkg::itjm_out_t             out_data
);
  import itjm_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_UPD  = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  logic [1:0]        bstate_r, bstate_nxt;
  itjm_cmd_t         cmd_r;
  logic              div_start, div_done;
  logic [MAG_W-1:0]  qmag;

  logic [TS_W-1:0]        samples_r, viol_r;
  logic signed [TS_W-1:0] jit_last_r, jit_lo_r, jit_hi_r;
  logic [TS_W-1:0]        exec_last_r, exec_lo_r, exec_hi_r;
  logic                   jit_seen_r, exec_seen_r;
  logic                   out_valid_r;
  itjm_out_t              out_r;

  logic                   pos_ovf, neg_ovf, load_out, is_viol;
  logic [TS_W-1:0]        neg_q, jit_abs, exec_us;
  logic signed [TS_W-1:0] jit;

  assign q_pop     = (bstate_r == B_IDLE) && !q_empty;
  assign div_start = q_pop && ((q_data.op == OP_JITTER) || (q_data.op == OP_EXEC));

  itjm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_data.mag),
    .divisor  (us_ticks),
    .done     (div_done),
    .quotient (qmag)
  );

  // Signed saturation of the quotient; magnitude of the minimum is 2^31
  assign pos_ovf = |qmag[MAG_W-1:TS_W-1];
  assign neg_ovf = (|qmag[MAG_W-1:TS_W]) || (qmag[TS_W-1] && (|qmag[TS_W-2:0]));
  assign neg_q   = ~qmag[TS_W-1:0] + 1'b1;

  always_comb begin
    if (cmd_r.neg) begin
      jit     = neg_ovf ? {1'b1, {(TS_W - 1){1'b0}}} : neg_q;
      jit_abs = neg_ovf ? {1'b1, {(TS_W - 1){1'b0}}} : qmag[TS_W-1:0];
    end else begin
      jit     = pos_ovf ? {1'b0, {(TS_W - 1){1'b1}}} : qmag[TS_W-1:0];
      jit_abs = pos_ovf ? {1'b0, {(TS_W - 1){1'b1}}} : qmag[TS_W-1:0];
    end
  end

  assign is_viol  = (jit_abs > jit_limit_us);
  assign exec_us  = qmag[TS_W-1:0];
  assign load_out = (bstate_r == B_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    bstate_nxt = bstate_r;
    case (bstate_r)
      B_IDLE:  if (!q_empty) bstate_nxt = div_start ? B_DIV : B_UPD;
      B_DIV:   if (div_done) bstate_nxt = B_UPD;
      B_UPD:   bstate_nxt = B_OUT;
      B_OUT:   if (load_out) bstate_nxt = B_IDLE;
      default: bstate_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
    end
  end

  // Snapshot register; empty groups read as zero
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.samples_total    <= samples_r;
      out_r.violations_total <= viol_r;
      out_r.jitter_last      <= jit_seen_r ? jit_last_r : '0;
      out_r.jitter_min       <= jit_seen_r ? jit_lo_r : '0;
      out_r.jitter_max       <= jit_seen_r ? jit_hi_r : '0;
      out_r.exec_last        <= exec_seen_r ? exec_last_r : '0;
      out_r.exec_min         <= exec_seen_r ? exec_lo_r : '0;
      out_r.exec_max         <= exec_seen_r ? exec_hi_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Control and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= B_IDLE;
      out_valid_r <= 1'b0;
      samples_r   <= '0;
      viol_r      <= '0;
      jit_last_r  <= '0;
      jit_lo_r    <= '0;
      jit_hi_r    <= '0;
      exec_last_r <= '0;
      exec_lo_r   <= '0;
      exec_hi_r   <= '0;
      jit_seen_r  <= 1'b0;
      exec_seen_r <= 1'b0;
    end else begin
      bstate_r <= bstate_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (bstate_r == B_UPD) begin
        case (cmd_r.op)
          OP_JITTER: begin
            jit_last_r <= jit;
            jit_seen_r <= 1'b1;
            if (!jit_seen_r || (jit < jit_lo_r)) jit_lo_r <= jit;
            if (!jit_seen_r || (jit > jit_hi_r)) jit_hi_r <= jit;
            if (samples_r != '1) samples_r <= samples_r + 1'b1;
            if (is_viol && (viol_r != '1)) viol_r <= viol_r + 1'b1;
          end
          OP_EXEC: begin
            exec_last_r <= exec_us;
            exec_seen_r <= 1'b1;
            if (!exec_seen_r || (exec_us < exec_lo_r)) exec_lo_r <= exec_us;
            if (!exec_seen_r || (exec_us > exec_hi_r)) exec_hi_r <= exec_us;
          end
          OP_CLEAR: begin
            samples_r   <= '0;
            viol_r      <= '0;
            jit_last_r  <= '0;
            jit_lo_r    <= '0;
            jit_hi_r    <= '0;
            exec_last_r <= '0;
            exec_lo_r   <= '0;
            exec_hi_r   <= '0;
            jit_seen_r  <= 1'b0;
            exec_seen_r <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  `ITJM_ASSERT_IMPL(a_jit_order, jit_seen_r, jit_lo_r <= jit_hi_r, "jitter min above max")
  `ITJM_ASSERT_IMPL(a_exec_order, exec_seen_r, exec_lo_r <= exec_hi_r, "exec min above max")
  `ITJM_ASSERT_NEXT(a_samples_mono, (bstate_r == B_UPD) && (cmd_r.op != OP_CLEAR), samples_r >= $past(samples_r), "sample count went down")

endmodule

`default_nettype wire

>>> src/irq_timing_jitter_monitor_unit.sv
// Top level of the interrupt timing jitter monitor: config registers and wiring.
// Usage:
//   in_*  : one item per event (entry, exit, clear statistics, read only) with
//           its cycle counter timestamp; accepted when in_valid && in_ready.
//   out_* : one statistics snapshot per item, in item order, valid/ready.
//   cfg_* : register writes (0 cycles per us, 1 ideal period us, 2 threshold
//           us), always ready, index 3 ignored; write only while idle.
// Flow:
//   The front end holds an item through accept, period product and queue
//   push. Entry and exit events that yield a measurement then run a
//   42-step serial divider in the back end, one quotient bit per cycle;
//   other items skip it. The front end takes the next item while the back
//   end divides, and the divider sets the sustained rate of such items.
// Reset:
//   rst_n (synchronous, low) clears the registers, the statistics, the
//   entry reference and the queue; no clearing pass follows.
// Stall:
//   A waiting result sits in the output register while the back end works on
//   the next command and the front end keeps filling the queue; once both are
//   full, in_ready stays low until out_ready takes the result.
`timescale 1ns / 1ps
`default_nettype none

module irq_timing_jitter_monitor_unit #(
  parameter int Q_DEPTH = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire itjm_pkg::itjm_in_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output itjm_pkg::itjm_out_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [itjm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [itjm_pkg::TS_W-1:0]      cfg_data
);
  import itjm_pkg::*;

  logic [CPU_W-1:0] cpu_r;
  logic [TS_W-1:0]  ideal_r, thresh_r;

  logic       q_push, q_full, q_pop, q_empty;
  itjm_cmd_t  q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_r    <= '0;
      ideal_r  <= '0;
      thresh_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CYCLES_PER_US: cpu_r    <= cfg_data[CPU_W-1:0];
        CFG_IDEAL_PERIOD:  ideal_r  <= cfg_data;
        CFG_THRESHOLD:     thresh_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  itjm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .us_ticks       (cpu_r),
    .period_goal_us (ideal_r),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .q_full         (q_full)
  );

  itjm_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  itjm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .us_ticks     (cpu_r),
    .jit_limit_us (thresh_r),
    .q_pop        (q_pop),
    .q_data       (q_rdata),
    .q_empty      (q_empty),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for the interrupt timing jitter monitor: table-driven and random events vs a model.
`timescale 1ns / 1ps

module tb;
  import itjm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint JIT_MAX = 64'sd2147483647;
  localparam longint JIT_MIN = -64'sd2147483648;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 123;
  localparam int HOLD_PHASE = 4;
  localparam int PAUSE_PHASE = 5;
  localparam int LONG_HOLD = 600;
  localparam int TAIL_CYCLES = 80;
  localparam itjm_out_t NO_STATS = '0;
  // one jitter sample of zero, nothing else
  localparam itjm_out_t FIRST_SAMPLE = '{32'd1, 32'd0, 32'sd0, 32'sd0, 32'sd0,
                                        32'd0, 32'd0, 32'd0};

  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [31:0]          cfg_val;
    itjm_in_t             ev;
    bit                   typed;
    itjm_out_t            want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  itjm_in_t in_data;
  logic out_valid;
  logic out_ready;
  itjm_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  // model copy of the registers
  logic [9:0]  tick_rate = '0;
  logic [31:0] period_us = '0;
  logic [31:0] limit_us = '0;

  // model copy of the statistics
  logic [31:0] last_entry_ts = '0;
  logic [31:0] ref_ts = '0;
  bit primed = 0;
  bit jit_valid = 0;
  bit exec_any = 0;
  logic [31:0] n_samples = '0;
  logic [31:0] n_violations = '0;
  logic signed [31:0] jit_now = '0;
  logic signed [31:0] jit_lo = '0;
  logic signed [31:0] jit_hi = '0;
  logic [31:0] exec_now = '0;
  logic [31:0] exec_lo = '0;
  logic [31:0] exec_hi = '0;

  itjm_out_t pending_snapshots [$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit calm = 0;
  bit hold_request = 0;
  logic [31:0] entry_ts = '0;

  irq_timing_jitter_monitor_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [31:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic plan_row_t ev_row(input logic [1:0] mode, input logic [31:0] ts,
                                       input bit typed, input itjm_out_t want);
    plan_row_t r;
    r = '0;
    r.ev.mode = mode;
    r.ev.timestamp = ts;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Directed events; typed-in snapshots where the answer is obvious
  plan_row_t directed_plan [30] = '{
    ev_row(MODE_ENTRY, 32'd100, 1'b1, NO_STATS),        // no timebase yet
    ev_row(MODE_EXIT, 32'd200, 1'b1, NO_STATS),
    ev_row(MODE_READ, 32'hFFFF_FFFF, 1'b1, NO_STATS),
    cfg_row(CFG_UNUSED, 32'hFFFF_FFFF),                 // ignored index
    cfg_row(CFG_CYCLES_PER_US, 32'd1),
    cfg_row(CFG_IDEAL_PERIOD, 32'd10),
    cfg_row(CFG_THRESHOLD, 32'd0),
    ev_row(MODE_EXIT, 32'd5, 1'b1, NO_STATS),           // exit before any entry
    ev_row(MODE_ENTRY, 32'd1000, 1'b1, NO_STATS),       // primes the reference
    ev_row(MODE_ENTRY, 32'd1010, 1'b1, FIRST_SAMPLE),   // exactly on period
    ev_row(MODE_ENTRY, 32'd1025, 1'b0, NO_STATS),
    ev_row(MODE_EXIT, 32'd1030, 1'b0, NO_STATS),
    ev_row(MODE_ENTRY, 32'd1032, 1'b0, NO_STATS),       // early arrival
    ev_row(MODE_CLEAR, 32'hFFFF_FFFF, 1'b1, NO_STATS),
    cfg_row(CFG_CYCLES_PER_US, 32'd1000),
    cfg_row(CFG_IDEAL_PERIOD, 32'hFFFF_FFFF),
    cfg_row(CFG_THRESHOLD, 32'h7FFF_FFFF),
    ev_row(MODE_ENTRY, 32'd0, 1'b0, NO_STATS),          // negative saturation
    ev_row(MODE_EXIT, 32'hFFFF_FFFF, 1'b0, NO_STATS),
    cfg_row(CFG_CYCLES_PER_US, 32'd1),
    cfg_row(CFG_IDEAL_PERIOD, 32'd0),
    cfg_row(CFG_THRESHOLD, 32'hFFFF_FFFF),
    ev_row(MODE_ENTRY, 32'hFFFF_FFFF, 1'b0, NO_STATS),  // positive saturation
    ev_row(MODE_EXIT, 32'hFFFF_FFFE, 1'b0, NO_STATS),   // longest handler time
    ev_row(MODE_ENTRY, 32'h7FFF_FFFF, 1'b0, NO_STATS),
    ev_row(MODE_READ, 32'd0, 1'b0, NO_STATS),
    cfg_row(CFG_CYCLES_PER_US, 32'd0),
    ev_row(MODE_ENTRY, 32'd5, 1'b0, NO_STATS),
    ev_row(MODE_CLEAR, 32'd0, 1'b1, NO_STATS),          // clear without timebase
    ev_row(MODE_EXIT, 32'd9, 1'b1, NO_STATS)
  };

  // Apply one event to the model state and return the snapshot it yields
  function automatic itjm_out_t advance_monitor(input itjm_in_t ev);
    longint ideal_cyc;
    longint diff;
    longint quot;
    longint mag;
    logic signed [31:0] jit;
    logic [31:0] us;
    itjm_out_t snap;

    if (ev.mode == MODE_CLEAR) begin
      n_samples = '0;
      n_violations = '0;
      jit_now = '0;
      jit_lo = '0;
      jit_hi = '0;
      exec_now = '0;
      exec_lo = '0;
      exec_hi = '0;
      jit_valid = 0;
      exec_any = 0;
    end else if (ev.mode == MODE_ENTRY && tick_rate != '0) begin
      last_entry_ts = ev.timestamp;
      if (!primed) begin
        ref_ts = ev.timestamp;
        primed = 1;
      end else begin
        ideal_cyc = longint'({32'd0, period_us}) * longint'({54'd0, tick_rate});
        diff = longint'({32'd0, ev.timestamp - ref_ts}) - ideal_cyc;
        ref_ts = ev.timestamp;
        quot = diff / longint'({54'd0, tick_rate});
        if (quot > JIT_MAX) jit = 32'sh7FFF_FFFF;
        else if (quot < JIT_MIN) jit = 32'sh8000_0000;
        else jit = quot[31:0];
        jit_now = jit;
        if (!jit_valid) begin
          jit_lo = jit;
          jit_hi = jit;
          jit_valid = 1;
        end else begin
          if (jit < jit_lo) jit_lo = jit;
          if (jit > jit_hi) jit_hi = jit;
        end
        if (n_samples != '1) n_samples++;
        mag = (jit < 0) ? -longint'(jit) : longint'(jit);
        if (mag > longint'({32'd0, limit_us}) && n_violations != '1) n_violations++;
      end
    end else if (ev.mode == MODE_EXIT && tick_rate != '0 && primed) begin
      us = (ev.timestamp - last_entry_ts) / {22'd0, tick_rate};
      exec_now = us;
      if (!exec_any) begin
        exec_lo = us;
        exec_hi = us;
        exec_any = 1;
      end else begin
        if (us < exec_lo) exec_lo = us;
        if (us > exec_hi) exec_hi = us;
      end
    end

    snap = '0;
    snap.samples_total = n_samples;
    snap.violations_total = n_violations;
    if (jit_valid) begin
      snap.jitter_last = jit_now;
      snap.jitter_min = jit_lo;
      snap.jitter_max = jit_hi;
    end
    if (exec_any) begin
      snap.exec_last = exec_now;
      snap.exec_min = exec_lo;
      snap.exec_max = exec_hi;
    end
    return snap;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result receiver: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_request = 0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v)
      report($sformatf("%s expected %h actual %h", name, exp_v, act_v));
  endtask

  // Snapshot checker
  always @(posedge clk) begin
    itjm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_snapshots.size() == 0) begin
        report("snapshot with no event waiting");
      end else begin
        want = pending_snapshots.pop_front();
        compare_field("samples_total", want.samples_total, out_data.samples_total);
        compare_field("violations_total", want.violations_total,
                      out_data.violations_total);
        compare_field("jitter_last", want.jitter_last, out_data.jitter_last);
        compare_field("jitter_min", want.jitter_min, out_data.jitter_min);
        compare_field("jitter_max", want.jitter_max, out_data.jitter_max);
        compare_field("exec_last", want.exec_last, out_data.exec_last);
        compare_field("exec_min", want.exec_min, out_data.exec_min);
        compare_field("exec_max", want.exec_max, out_data.exec_max);
      end
    end
  end

  // Drop valid and wait until every snapshot is back
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pending_snapshots.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    wait_for_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CYCLES_PER_US: tick_rate = val[9:0];
      CFG_IDEAL_PERIOD:  period_us = val;
      CFG_THRESHOLD:     limit_us = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic idle_gap();
    if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Offer one event; on acceptance record the snapshot it must produce
  task automatic send_event(input itjm_in_t ev, input bit typed, input itjm_out_t want);
    itjm_out_t predicted;
    in_data = ev;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_monitor(ev);
    pending_snapshots.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // One random phase: new settings, then mostly periodic entry/exit pairs
  task automatic run_phase(input int phase);
    itjm_in_t ev;
    logic [9:0] rate;
    logic [31:0] period_cyc;
    longint span;
    longint offset;
    int pick;
    bit want_exit;

    case (phase)
      0: begin
        write_reg(CFG_CYCLES_PER_US, 32'd1000);
        write_reg(CFG_IDEAL_PERIOD, 32'hFFFF_FFFF);
        write_reg(CFG_THRESHOLD, 32'd0);
      end
      1: begin
        write_reg(CFG_CYCLES_PER_US, 32'd1);
        write_reg(CFG_IDEAL_PERIOD, 32'd0);
        write_reg(CFG_THRESHOLD, 32'hFFFF_FFFF);
      end
      2: begin
        write_reg(CFG_CYCLES_PER_US, 32'd0);
        write_reg(CFG_IDEAL_PERIOD, $urandom_range(1, 20000));
        write_reg(CFG_THRESHOLD, $urandom_range(0, 40));
      end
      default: begin
        write_reg(CFG_CYCLES_PER_US, $urandom_range(1, 1000));
        write_reg(CFG_IDEAL_PERIOD, $urandom_range(1, 20000));
        write_reg(CFG_THRESHOLD, $urandom_range(0, 40));
        write_reg(CFG_UNUSED, $urandom);
      end
    endcase

    case (phase % 3)
      0:       idle_pct = 0;
      1:       idle_pct = 12;
      default: idle_pct = 40;
    endcase
    stall_pct = $urandom_range(0, 3) * 15;
    calm = (phase == PHASES - 1);
    if (phase == HOLD_PHASE) hold_request = 1;

    rate = (tick_rate == '0) ? 10'd1 : tick_rate;
    period_cyc = period_us * {22'd0, rate};
    span = longint'({54'd0, rate}) * (longint'({32'd0, limit_us}) + 8);
    if (span > 64'sd1_000_000_000) span = 64'sd1_000_000_000;
    want_exit = 0;

    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (phase == PAUSE_PHASE && i == PHASE_ITEMS / 2) wait_for_results();
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        ev.mode = MODE_CLEAR;
        ev.timestamp = $urandom;
      end else if (pick < 7) begin
        ev.mode = MODE_READ;
        ev.timestamp = $urandom;
      end else if (pick < 15) begin
        // noise: any mode at any time
        ev.mode = 2'($urandom_range(0, 3));
        ev.timestamp = $urandom;
      end else if (want_exit) begin
        ev.mode = MODE_EXIT;
        ev.timestamp = entry_ts + $urandom_range(0, {22'd0, rate} * 300);
        want_exit = 0;
      end else begin
        offset = longint'($urandom_range(0, 32'(2 * span))) - span;
        entry_ts = entry_ts + period_cyc + offset[31:0];
        ev.mode = MODE_ENTRY;
        ev.timestamp = entry_ts;
        want_exit = ($urandom_range(0, 3) != 0);
      end
      idle_gap();
      send_event(ev, 1'b0, NO_STATS);
    end
  endtask

  // Main sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    idle_pct = 20;
    stall_pct = 20;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        write_reg(directed_plan[i].cfg_idx, directed_plan[i].cfg_val);
      end else begin
        idle_gap();
        send_event(directed_plan[i].ev, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) run_phase(p);

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/itjm_pkg.sv
src/itjm_queue.sv
src/itjm_front.sv
src/itjm_div.sv
src/itjm_back.sv
src/irq_timing_jitter_monitor_unit.sv
dv/tb.sv
